### hdl/ffsa_pkg.sv
// Shared types and codes for the first-fit segment allocator.
// No dependencies; every other file but ffsa_alu refers to it by scoped names.
`default_nettype none
package ffsa_pkg;

  localparam int ARENA_BYTES_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int OFFSET_W = 12;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 4;
  localparam int TAG_W    = 2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [TAG_W-1:0] TAG_NONE = 2'd0;
  localparam logic [TAG_W-1:0] TAG_FREE = 2'd1;
  localparam logic [TAG_W-1:0] TAG_USED = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO         = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FRAGMENTED   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_SHORT        = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 4'd8;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 4'd9;

endpackage
`default_nettype wire

### hdl/ffsa_alu.sv
// Shared add/subtract unit of the allocator sequencer.
// Standalone; used by ffsa_ctrl.
`default_nettype none
module ffsa_alu #(
  parameter int W = 14
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] y,
  output logic              ge
);

  logic [W:0] full;

  always_comb begin
    if (sub) begin
      full = {1'b0, a} + {1'b0, ~b} + (W+1)'(1);
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign y  = full[W-1:0];
  // carry out of a - b means no borrow
  assign ge = full[W];

endmodule
`default_nettype wire

### hdl/ffsa_hdr_mem.sv
// Header store: one tag/size entry per arena byte offset.
// One write and one registered read per cycle; uses ffsa_pkg for the tag width.
`default_nettype none
module ffsa_hdr_mem #(
  parameter int ARENA_BYTES = ffsa_pkg::ARENA_BYTES_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [$clog2(ARENA_BYTES)-1:0]               waddr,
  input  wire logic [ffsa_pkg::TAG_W+$clog2(ARENA_BYTES)-1:0] wdata,
  input  wire logic [$clog2(ARENA_BYTES)-1:0]               raddr,
  output logic      [ffsa_pkg::TAG_W+$clog2(ARENA_BYTES)-1:0] rdata
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int EW = ffsa_pkg::TAG_W + AW;

  logic [EW-1:0] mem [ARENA_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/ffsa_ctrl.sv
// Sequencer of the allocator: header clear, list walk, split, free lookup and merge pass.
// Uses ffsa_pkg and ffsa_alu; drives the header store port.
`default_nettype none
module ffsa_ctrl #(
  parameter int ARENA_BYTES  = ffsa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           req_valid,
  output logic                                                req_stall,
  input  wire logic                                           action,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]                    alloc_bytes,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0]                  payload_offset,
  output logic                                                rsp_valid,
  input  wire logic                                           rsp_stall,
  output logic      [ffsa_pkg::OFFSET_W-1:0]                  granted_offset,
  output logic      [ffsa_pkg::STATUS_W-1:0]                  status,
  output logic                                                mem_we,
  output logic      [$clog2(ARENA_BYTES)-1:0]                 mem_waddr,
  output logic      [ffsa_pkg::TAG_W+$clog2(ARENA_BYTES)-1:0] mem_wdata,
  output logic      [$clog2(ARENA_BYTES)-1:0]                 mem_raddr,
  input  wire logic [ffsa_pkg::TAG_W+$clog2(ARENA_BYTES)-1:0] mem_rdata
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int DW = AW + 2;

  localparam logic [DW-1:0] H1      = DW'(HEADER_BYTES + 1);
  localparam logic [DW-1:0] ARENA_D = DW'(ARENA_BYTES);
  localparam logic [DW-1:0] MAXSZ_D = DW'(ARENA_BYTES - HEADER_BYTES - 1);
  localparam logic [31:0]   MAXSZ_W = 32'(ARENA_BYTES - HEADER_BYTES - 1);
  localparam logic [31:0]   H1_W    = 32'(HEADER_BYTES + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLEAR    = 5'd1;
  localparam logic [4:0] S_A_CHK    = 5'd2;
  localparam logic [4:0] S_A_RD     = 5'd3;
  localparam logic [4:0] S_A_TAG    = 5'd4;
  localparam logic [4:0] S_A_FIT    = 5'd5;
  localparam logic [4:0] S_A_SPAN   = 5'd6;
  localparam logic [4:0] S_A_NEXT   = 5'd7;
  localparam logic [4:0] S_A_FAIL   = 5'd8;
  localparam logic [4:0] S_A_USE    = 5'd9;
  localparam logic [4:0] S_A_TAIL   = 5'd10;
  localparam logic [4:0] S_F_CHK    = 5'd11;
  localparam logic [4:0] S_F_RDH    = 5'd12;
  localparam logic [4:0] S_F_TAGH   = 5'd13;
  localparam logic [4:0] S_F_RD     = 5'd14;
  localparam logic [4:0] S_F_TAG    = 5'd15;
  localparam logic [4:0] S_F_SPAN   = 5'd16;
  localparam logic [4:0] S_F_NEXT   = 5'd17;
  localparam logic [4:0] S_C_RD     = 5'd18;
  localparam logic [4:0] S_C_TAG    = 5'd19;
  localparam logic [4:0] S_C_SPAN   = 5'd20;
  localparam logic [4:0] S_C_NXT    = 5'd21;
  localparam logic [4:0] S_C_RDN    = 5'd22;
  localparam logic [4:0] S_C_TAGN   = 5'd23;
  localparam logic [4:0] S_C_MRG    = 5'd24;
  localparam logic [4:0] S_C_ADVSP  = 5'd25;
  localparam logic [4:0] S_C_ADV    = 5'd26;
  localparam logic [4:0] S_DONE     = 5'd27;

  logic [4:0]                      state;
  logic [DW-1:0]                   pos;
  logic [DW-1:0]                   aux;
  logic [DW-1:0]                   tmp;
  logic [DW-1:0]                   sum;
  logic [AW-1:0]                   sz;
  logic [ffsa_pkg::SIZE_W-1:0]     req;
  logic [ffsa_pkg::OFFSET_W-1:0]   pay;
  logic                            arena_ready;
  logic [ffsa_pkg::STATUS_W-1:0]   code;
  logic [ffsa_pkg::OFFSET_W-1:0]   gnt;

  logic [DW-1:0]                   alu_a;
  logic [DW-1:0]                   alu_b;
  logic                            alu_sub;
  logic [DW-1:0]                   alu_y;
  logic                            alu_ge;

  logic [ffsa_pkg::TAG_W-1:0]      rd_tag;
  logic [AW-1:0]                   rd_size;

  assign rd_tag  = mem_rdata[ffsa_pkg::TAG_W+AW-1:AW];
  assign rd_size = mem_rdata[AW-1:0];
  assign req_stall = (state != S_IDLE);

  ffsa_alu #(.W(DW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y),
    .ge  (alu_ge)
  );

  always_comb begin
    alu_a     = pos;
    alu_b     = tmp;
    alu_sub   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = '0;
    mem_raddr = pos[AW-1:0];
    unique case (state) inside
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_A_CHK: begin
        alu_a = DW'(req);
        alu_b = H1;
        // first allocate that passes the size checks lays down one segment over the arena
        if (!arena_ready && 32'(req) <= MAXSZ_W && req != '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {ffsa_pkg::TAG_FREE, MAXSZ_D[AW-1:0]};
        end
      end
      S_A_TAG: begin
        alu_a = sum;
        alu_b = DW'(rd_size);
      end
      S_A_FIT: begin
        alu_a   = DW'(sz);
        alu_b   = aux;
        alu_sub = 1'b1;
      end
      S_A_SPAN, S_F_SPAN, S_C_SPAN, S_C_ADVSP: begin
        alu_a = DW'(sz);
        alu_b = H1;
      end
      S_A_USE: begin
        mem_we    = 1'b1;
        mem_wdata = {ffsa_pkg::TAG_USED, AW'(req)};
        alu_b     = aux;
      end
      S_A_TAIL: begin
        mem_we    = (aux < ARENA_D);
        mem_waddr = aux[AW-1:0];
        mem_wdata = {ffsa_pkg::TAG_FREE, tmp[AW-1:0]};
        alu_b     = H1;
      end
      S_F_CHK: begin
        alu_a   = DW'(pay);
        alu_b   = H1;
        alu_sub = 1'b1;
      end
      S_F_RDH, S_C_RDN: begin
        mem_raddr = aux[AW-1:0];
      end
      S_F_TAG: begin
        mem_we    = (pos == aux);
        mem_wdata = {ffsa_pkg::TAG_FREE, rd_size};
      end
      S_C_TAGN: begin
        alu_a = DW'(rd_size);
        alu_b = H1;
      end
      S_C_MRG: begin
        alu_a     = DW'(sz);
        mem_we    = 1'b1;
        mem_wdata = {ffsa_pkg::TAG_FREE, alu_y[AW-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      pos         <= '0;
      arena_ready <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (pos == ARENA_D - DW'(1)) begin
            state <= S_IDLE;
          end
          pos <= pos + DW'(1);
        end
        S_IDLE: begin
          if (req_valid) begin
            req   <= alloc_bytes;
            pay   <= payload_offset;
            gnt   <= '0;
            state <= (action == ffsa_pkg::ACT_FREE) ? S_F_CHK : S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (32'(req) > MAXSZ_W) begin
            code  <= ffsa_pkg::ST_TOO_LARGE;
            state <= S_DONE;
          end else if (req == '0) begin
            code  <= ffsa_pkg::ST_ZERO;
            state <= S_DONE;
          end else begin
            arena_ready <= 1'b1;
            aux         <= alu_y;
            pos         <= '0;
            sum         <= '0;
            state       <= S_A_RD;
          end
        end
        S_A_RD: state <= S_A_TAG;
        S_A_TAG: begin
          sz <= rd_size;
          if (rd_tag == ffsa_pkg::TAG_FREE) begin
            sum   <= alu_y;
            state <= S_A_FIT;
          end else begin
            state <= S_A_SPAN;
          end
        end
        S_A_FIT: begin
          if (alu_ge) begin
            tmp   <= alu_y;
            state <= S_A_USE;
          end else begin
            state <= S_A_SPAN;
          end
        end
        S_A_SPAN: begin
          tmp   <= alu_y;
          state <= S_A_NEXT;
        end
        S_A_NEXT: begin
          if (alu_y >= ARENA_D) begin
            state <= S_A_FAIL;
          end else begin
            pos   <= alu_y;
            state <= S_A_RD;
          end
        end
        S_A_FAIL: begin
          if (sum == '0) begin
            code <= ffsa_pkg::ST_NONE_FREE;
          end else if (sum >= aux) begin
            code <= ffsa_pkg::ST_FRAGMENTED;
          end else begin
            code <= ffsa_pkg::ST_SHORT;
          end
          state <= S_DONE;
        end
        S_A_USE: begin
          aux   <= alu_y;
          state <= S_A_TAIL;
        end
        S_A_TAIL: begin
          gnt   <= ffsa_pkg::OFFSET_W'(alu_y);
          code  <= ffsa_pkg::ST_OK;
          state <= S_DONE;
        end
        S_F_CHK: begin
          if (32'(pay) < H1_W || 32'(pay) > MAXSZ_W) begin
            code  <= ffsa_pkg::ST_BAD_ADDR;
            state <= S_DONE;
          end else begin
            aux   <= alu_y;
            state <= S_F_RDH;
          end
        end
        S_F_RDH: state <= S_F_TAGH;
        S_F_TAGH: begin
          if (rd_tag == ffsa_pkg::TAG_NONE) begin
            code  <= ffsa_pkg::ST_NOT_ALLOC;
            state <= S_DONE;
          end else if (rd_tag == ffsa_pkg::TAG_FREE) begin
            code  <= ffsa_pkg::ST_ALREADY_FREE;
            state <= S_DONE;
          end else begin
            pos   <= '0;
            state <= S_F_RD;
          end
        end
        S_F_RD: state <= S_F_TAG;
        S_F_TAG: begin
          sz <= rd_size;
          if (pos == aux) begin
            pos   <= '0;
            state <= S_C_RD;
          end else begin
            state <= S_F_SPAN;
          end
        end
        S_F_SPAN: begin
          tmp   <= alu_y;
          state <= S_F_NEXT;
        end
        S_F_NEXT: begin
          if (alu_y >= ARENA_D) begin
            code  <= ffsa_pkg::ST_NOT_FOUND;
            state <= S_DONE;
          end else begin
            pos   <= alu_y;
            state <= S_F_RD;
          end
        end
        S_C_RD: state <= S_C_TAG;
        S_C_TAG: begin
          sz    <= rd_size;
          state <= (rd_tag == ffsa_pkg::TAG_FREE) ? S_C_SPAN : S_C_ADVSP;
        end
        S_C_SPAN: begin
          tmp   <= alu_y;
          state <= S_C_NXT;
        end
        S_C_NXT: begin
          if (alu_y >= ARENA_D) begin
            code  <= ffsa_pkg::ST_OK;
            state <= S_DONE;
          end else begin
            aux   <= alu_y;
            state <= S_C_RDN;
          end
        end
        S_C_RDN: state <= S_C_TAGN;
        S_C_TAGN: begin
          if (rd_tag == ffsa_pkg::TAG_FREE) begin
            tmp   <= alu_y;
            state <= S_C_MRG;
          end else begin
            // skip past the used neighbor
            sz    <= rd_size;
            pos   <= aux;
            state <= S_C_ADVSP;
          end
        end
        S_C_MRG: begin
          sz    <= alu_y[AW-1:0];
          state <= S_C_SPAN;
        end
        S_C_ADVSP: begin
          tmp   <= alu_y;
          state <= S_C_ADV;
        end
        S_C_ADV: begin
          if (alu_y >= ARENA_D) begin
            code  <= ffsa_pkg::ST_OK;
            state <= S_DONE;
          end else begin
            pos   <= alu_y;
            state <= S_C_RD;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            status         <= code;
            granted_offset <= gnt;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while a transaction is in progress");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ffsa_pkg::ST_OK |-> granted_offset == '0)
    else $error("nonzero offset returned with an error status");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !rsp_valid)
    else $error("response raised during the header clearing pass");

  a_walk_in_arena: assert property (@(posedge clk) disable iff (rst)
    state == S_A_RD || state == S_F_RD || state == S_C_RD |-> pos < ARENA_D)
    else $error("list walk left the arena");

endmodule
`default_nettype wire

### hdl/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator.
// Uses ffsa_pkg, ffsa_ctrl (sequencer with ffsa_alu) and ffsa_hdr_mem.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   request | req_valid / req_stall| action, alloc_bytes, payload_offset
//   response| rsp_valid / rsp_stall| granted_offset, status
//
// One request at a time; each list node visited costs a header read, then
// the tag, fit (free nodes only), span and next states, so latency grows
// with fragmentation. A free adds the merge pass over the segments.
// After reset the header store is cleared at one entry a cycle, req_stall
// high throughout. A finished response waits in its output register while
// rsp_stall is high; the next request can be taken meanwhile.
`default_nettype none
module first_fit_segment_allocator_unit #(
  parameter int ARENA_BYTES  = ffsa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic                              action,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]       alloc_bytes,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0]     payload_offset,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic      [ffsa_pkg::OFFSET_W-1:0]     granted_offset,
  output logic      [ffsa_pkg::STATUS_W-1:0]     status
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int EW = ffsa_pkg::TAG_W + AW;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  ffsa_ctrl #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .action         (action),
    .alloc_bytes    (alloc_bytes),
    .payload_offset (payload_offset),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .granted_offset (granted_offset),
    .status         (status),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  ffsa_hdr_mem #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_hdr_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

### bench/ffsa_scoreboard.sv
// Watches the request and response channels of the allocator, predicts each response
// from its own copy of the segment list and compares field by field.
// Depends on ffsa_pkg.
module ffsa_scoreboard #(
  parameter int ARENA_BYTES  = ffsa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic                              req_stall,
  input  logic                              action,
  input  logic [ffsa_pkg::SIZE_W-1:0]       alloc_bytes,
  input  logic [ffsa_pkg::OFFSET_W-1:0]     payload_offset,
  input  logic                              rsp_valid,
  input  logic                              rsp_stall,
  input  logic [ffsa_pkg::OFFSET_W-1:0]     granted_offset,
  input  logic [ffsa_pkg::STATUS_W-1:0]     status,
  output int                                fail_count,
  output int                                pending
);

  typedef struct packed {
    logic [ffsa_pkg::OFFSET_W-1:0] offset;
    logic [ffsa_pkg::STATUS_W-1:0] code;
  } grant_t;

  logic [ffsa_pkg::TAG_W-1:0] seg_tag [ARENA_BYTES];
  int unsigned                seg_len [ARENA_BYTES];
  bit                         arena_init;
  grant_t                     grants_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
    arena_init = 0;
    for (int i = 0; i < ARENA_BYTES; i++) begin
      seg_tag[i] = ffsa_pkg::TAG_NONE;
      seg_len[i] = 0;
    end
  end

  function automatic int unsigned next_segment(int unsigned pos);
    int unsigned n;
    if (pos >= ARENA_BYTES) return ARENA_BYTES;
    n = pos + seg_len[pos] + HEADER_BYTES + 1;
    if (n >= ARENA_BYTES) return ARENA_BYTES;
    return n;
  endfunction

  function automatic grant_t carve(int unsigned req);
    int unsigned need, pos, free_sum, fit, tail;
    bit found;
    grant_t g;
    g.offset = '0;
    free_sum = 0;
    found = 0;
    fit = 0;
    if (req > ARENA_BYTES - HEADER_BYTES - 1) begin
      g.code = ffsa_pkg::ST_TOO_LARGE;
      return g;
    end
    if (req == 0) begin
      g.code = ffsa_pkg::ST_ZERO;
      return g;
    end
    if (!arena_init) begin
      seg_tag[0] = ffsa_pkg::TAG_FREE;
      seg_len[0] = ARENA_BYTES - HEADER_BYTES - 1;
      arena_init = 1;
    end
    need = req + HEADER_BYTES + 1;
    pos = 0;
    for (int guard = 0; guard < ARENA_BYTES && pos < ARENA_BYTES; guard++) begin
      if (seg_tag[pos] == ffsa_pkg::TAG_FREE) begin
        free_sum += seg_len[pos];
        if (seg_len[pos] >= need) begin
          fit = pos;
          found = 1;
          break;
        end
      end
      pos = next_segment(pos);
    end
    if (!found) begin
      if (free_sum == 0) g.code = ffsa_pkg::ST_NONE_FREE;
      else if (free_sum >= need) g.code = ffsa_pkg::ST_FRAGMENTED;
      else g.code = ffsa_pkg::ST_SHORT;
      return g;
    end
    tail = fit + need;
    if (tail < ARENA_BYTES) begin
      seg_tag[tail] = ffsa_pkg::TAG_FREE;
      seg_len[tail] = seg_len[fit] - need;
    end
    seg_tag[fit] = ffsa_pkg::TAG_USED;
    seg_len[fit] = req;
    g.offset = ffsa_pkg::OFFSET_W'(fit + HEADER_BYTES + 1);
    g.code = ffsa_pkg::ST_OK;
    return g;
  endfunction

  // Absorb each free neighbor into the free segment ahead of it; old headers stay.
  function automatic void merge_free_runs();
    int unsigned cur, nxt;
    cur = 0;
    for (int guard = 0; guard < 2 * ARENA_BYTES && cur < ARENA_BYTES; guard++) begin
      if (seg_tag[cur] == ffsa_pkg::TAG_FREE) begin
        nxt = next_segment(cur);
        if (nxt >= ARENA_BYTES) return;
        if (seg_tag[nxt] == ffsa_pkg::TAG_FREE)
          seg_len[cur] += seg_len[nxt] + HEADER_BYTES + 1;
        else cur = next_segment(nxt);
      end else begin
        cur = next_segment(cur);
      end
    end
  endfunction

  function automatic grant_t release_segment(int unsigned p);
    int unsigned h, pos;
    grant_t g;
    g.offset = '0;
    if (p < HEADER_BYTES + 1 || p > ARENA_BYTES - HEADER_BYTES - 1) begin
      g.code = ffsa_pkg::ST_BAD_ADDR;
      return g;
    end
    h = p - HEADER_BYTES - 1;
    if (seg_tag[h] == ffsa_pkg::TAG_NONE) begin
      g.code = ffsa_pkg::ST_NOT_ALLOC;
      return g;
    end
    if (seg_tag[h] == ffsa_pkg::TAG_FREE) begin
      g.code = ffsa_pkg::ST_ALREADY_FREE;
      return g;
    end
    pos = 0;
    for (int guard = 0; guard < ARENA_BYTES && pos < ARENA_BYTES; guard++) begin
      if (pos == h) begin
        seg_tag[pos] = ffsa_pkg::TAG_FREE;
        merge_free_runs();
        g.code = ffsa_pkg::ST_OK;
        return g;
      end
      pos = next_segment(pos);
    end
    g.code = ffsa_pkg::ST_NOT_FOUND;
    return g;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (grants_due.size() == 0) begin
          report($sformatf("unexpected response offset %0d status %0d",
                           granted_offset, status));
        end else begin
          want = grants_due.pop_front();
          if (granted_offset !== want.offset)
            report($sformatf("granted_offset %0d, want %0d", granted_offset, want.offset));
          if (status !== want.code)
            report($sformatf("status %0d, want %0d", status, want.code));
        end
      end
      if (req_valid && !req_stall) begin
        if (action == ffsa_pkg::ACT_ALLOC) grants_due.push_back(carve(alloc_bytes));
        else grants_due.push_back(release_segment(payload_offset));
      end
      pending = grants_due.size();
    end
  end

endmodule

### bench/first_fit_segment_allocator_unit_test.sv
// Stimulus and verdict for the first-fit segment allocator.
// Depends on ffsa_pkg, first_fit_segment_allocator_unit and ffsa_scoreboard.
module first_fit_segment_allocator_unit_test;

  localparam int ARENA  = ffsa_pkg::ARENA_BYTES_DEF;
  localparam int HDR    = ffsa_pkg::HEADER_BYTES_DEF;
  localparam int SW     = ffsa_pkg::SIZE_W;
  localparam int OW     = ffsa_pkg::OFFSET_W;
  localparam int RANDOM_ITEMS = 1900;
  localparam longint CYCLE_LIMIT = 200_000_000;

  logic                          clk;
  logic                          rst;
  logic                          req_valid;
  logic                          req_stall;
  logic                          action;
  logic [SW-1:0]                 alloc_bytes;
  logic [OW-1:0]                 payload_offset;
  logic                          rsp_valid;
  logic                          rsp_stall;
  logic [OW-1:0]                 granted_offset;
  logic [ffsa_pkg::STATUS_W-1:0] status;
  int                            fail_count;
  int                            pending;

  // idle mode: 0 none, 1 sender, 2 receiver, 3 both
  int                  idle_mode;
  int                  hold_off;
  longint              cycles;
  logic [OW-1:0]       live[$];
  logic [OW-1:0]       dead[$];

  first_fit_segment_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .action(action), .alloc_bytes(alloc_bytes), .payload_offset(payload_offset),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .granted_offset(granted_offset), .status(status)
  );

  ffsa_scoreboard i_scoreboard (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .action(action), .alloc_bytes(alloc_bytes), .payload_offset(payload_offset),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .granted_offset(granted_offset), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Track granted payloads so frees can target real segments.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall && status == ffsa_pkg::ST_OK && granted_offset != 0)
      live.push_back(granted_offset);
  end

  // Receiver: random stall per mode, plus a long hold-off when requested.
  initial begin
    rsp_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        rsp_stall = 1;
        hold_off--;
      end else if (idle_mode == 2) begin
        rsp_stall = ($urandom_range(99) < 66);
      end else if (idle_mode == 3) begin
        rsp_stall = ($urandom_range(99) < 15);
      end else begin
        rsp_stall = 0;
      end
    end
  end

  task automatic send(input logic act, input logic [SW-1:0] sz,
                      input logic [OW-1:0] off);
    int gap;
    gap = 0;
    if (idle_mode == 1) while ($urandom_range(99) < 66 && gap < 8) gap++;
    else if (idle_mode == 3) while ($urandom_range(99) < 15 && gap < 8) gap++;
    if (gap > 0) begin
      req_valid = 0;
      alloc_bytes = SW'($urandom);
      payload_offset = OW'($urandom);
      repeat (gap) @(negedge clk);
    end
    action = act;
    alloc_bytes = sz;
    payload_offset = off;
    req_valid = 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic alloc_item();
    int pick;
    logic [SW-1:0] sz;
    pick = $urandom_range(99);
    if (pick < 70) sz = SW'($urandom_range(300, 1));
    else if (pick < 88) sz = SW'($urandom_range(ARENA - HDR - 1, 301));
    else if (pick < 95) sz = SW'($urandom_range(65535, ARENA - HDR));
    else if (pick < 97) sz = SW'(ARENA - HDR - 1 + $urandom_range(1));
    else sz = 0;
    send(ffsa_pkg::ACT_ALLOC, sz, OW'($urandom));
  endtask

  task automatic free_item();
    int pick, idx;
    logic [OW-1:0] off;
    pick = $urandom_range(99);
    if (pick < 65 && live.size() > 0) begin
      idx = $urandom_range(live.size() - 1);
      off = live[idx];
      live.delete(idx);
      dead.push_back(off);
      if (dead.size() > 64) void'(dead.pop_front());
    end else if (pick < 85 && dead.size() > 0) begin
      // stale payloads: double free or used header absorbed by a merge
      off = dead[$urandom_range(dead.size() - 1)];
    end else if (pick < 92) begin
      off = OW'($urandom_range(HDR + 1));
    end else begin
      off = OW'($urandom);
    end
    send(ffsa_pkg::ACT_FREE, SW'($urandom), off);
  endtask

  initial begin
    rst = 1;
    req_valid = 0;
    action = ffsa_pkg::ACT_ALLOC;
    alloc_bytes = '0;
    payload_offset = '0;
    idle_mode = 0;
    hold_off = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: range edges, tag checks before the arena exists, fill to exhaustion
    send(ffsa_pkg::ACT_FREE, '0, OW'(HDR + 1));
    send(ffsa_pkg::ACT_ALLOC, '0, '0);
    send(ffsa_pkg::ACT_ALLOC, SW'(ARENA - HDR), '0);
    send(ffsa_pkg::ACT_ALLOC, 16'hFFFF, 12'hFFF);
    send(ffsa_pkg::ACT_FREE, '0, '0);
    send(ffsa_pkg::ACT_FREE, '0, OW'(HDR));
    send(ffsa_pkg::ACT_FREE, '0, OW'(ARENA - HDR));
    send(ffsa_pkg::ACT_FREE, 16'hFFFF, 12'hFFF);
    send(ffsa_pkg::ACT_ALLOC, 16'd1, '0);
    send(ffsa_pkg::ACT_ALLOC, 16'd4000, '0);
    send(ffsa_pkg::ACT_ALLOC, 16'd100, '0);
    send(ffsa_pkg::ACT_ALLOC, 16'd27, '0);
    send(ffsa_pkg::ACT_ALLOC, 16'd5, '0);
    send(ffsa_pkg::ACT_FREE, '0, OW'(HDR + 1));
    send(ffsa_pkg::ACT_FREE, '0, OW'(HDR + 1));
    send(ffsa_pkg::ACT_ALLOC, 16'd2, '0);
    send(ffsa_pkg::ACT_FREE, '0, OW'(ARENA - HDR - 1));
    send(ffsa_pkg::ACT_FREE, '0, OW'(2 * HDR + 3));
    send(ffsa_pkg::ACT_FREE, '0, OW'(4035 + HDR + 1));
    send(ffsa_pkg::ACT_ALLOC, SW'(ARENA - HDR - 1), '0);
    send(ffsa_pkg::ACT_ALLOC, 16'd3000, '0);
    send(ffsa_pkg::ACT_FREE, '0, OW'(HDR + 1));
    live.delete();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 475 == 0) begin
        idle_mode = (n / 475) % 4;
        if (idle_mode == 0) hold_off = 400;
      end
      if ($urandom_range(99) < (live.size() < 6 ? 75 : 50)) alloc_item();
      else free_item();
    end
    req_valid = 0;
    idle_mode = 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
hdl/ffsa_pkg.sv
hdl/ffsa_alu.sv
hdl/ffsa_hdr_mem.sv
hdl/ffsa_ctrl.sv
hdl/first_fit_segment_allocator_unit.sv
bench/ffsa_scoreboard.sv
bench/first_fit_segment_allocator_unit_test.sv
